@@ sv/windowed_class_mode_filter_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the windowed class mode filter
// Clocked on clk_i, with or without the active-low reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_CLASS_MODE_FILTER_ASSERT_SVH
`define WINDOWED_CLASS_MODE_FILTER_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define WCMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every rising edge, reset included.
`define WCMF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/wcmf_pkg.sv @@
// ----------------------------------------------------------------------------
// wcmf_pkg
// Beat types and constants of the windowed class mode filter.
// ----------------------------------------------------------------------------
package wcmf_pkg;

  localparam int unsigned NUM_BINS_DEF      = 16;
  localparam int unsigned WINDOW_LEN_DEF    = 100;
  localparam int unsigned RESTART_LIMIT_DEF = 1000;

  localparam int unsigned CNT_W   = 7;
  localparam int unsigned CLASS_W = 4;
  localparam int unsigned ID_W    = 8;

  localparam logic [CNT_W-1:0]   BIN_MAX         = 7'd127;
  localparam logic [CLASS_W-1:0] NUM_CLASSES_RST = 4'd4;

  typedef struct packed {
    logic            sample_valid;
    logic [ID_W-1:0] class_id;
  } wcmf_in_t;

  typedef struct packed {
    logic [CLASS_W-1:0] stable_class;
    logic               window_closed;
  } wcmf_out_t;

endpackage

@@ sv/wcmf_ram.sv @@
// ----------------------------------------------------------------------------
// wcmf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wcmf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/windowed_class_mode_filter.sv @@
// ----------------------------------------------------------------------------
// windowed_class_mode_filter
// Histogram of classification samples; every window picks the most frequent
// bin as the stable class.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 payload
//  -------   ---  ------------------------  ---------------------------------
//  in        in   in_valid_i / in_ready_o   in_data_i  (sample_valid, class_id)
//  out       out  out_valid_o / out_ready_i out_data_o (stable_class, closed)
//  cfg       in   cfg_we_i                  cfg_wdata_i (num_classes)
//
//  An ordinary beat passes the idle state that accepts it, the update state
//  that read-modify-writes its bin and the finish state that loads the output
//  register. A beat that closes a window also scans bins 0 to last, last =
//  min(num_classes, NUM_BINS-1): the scan walks the histogram RAM through
//  its one read port. Reset clears per-bin valid flops at once, so no
//  clearing pass is needed. A stalled output holds the next result in the
//  finish state; ready stays low until the result is loaded.
//
module windowed_class_mode_filter #(
  parameter int unsigned NUM_BINS      = wcmf_pkg::NUM_BINS_DEF,
  parameter int unsigned WINDOW_LEN    = wcmf_pkg::WINDOW_LEN_DEF,
  parameter int unsigned RESTART_LIMIT = wcmf_pkg::RESTART_LIMIT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wcmf_pkg::CLASS_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wcmf_pkg::wcmf_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wcmf_pkg::wcmf_out_t           out_data_o
);

  import wcmf_pkg::*;

  `include "windowed_class_mode_filter_assert.svh"

  // Bin index width, width for comparing against num_classes, counter widths.
  localparam int unsigned BW = $clog2(NUM_BINS);
  localparam int unsigned LW = (BW > CLASS_W) ? BW : CLASS_W;
  localparam int unsigned SW = $clog2(RESTART_LIMIT + 2);
  localparam int unsigned WW = $clog2(WINDOW_LEN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_SCAN,
    ST_SCAN_END,
    ST_FIN
  } state_e;

  state_e                state_q, state_d;
  logic [CLASS_W-1:0]    num_cls_q, num_cls_d;
  logic [NUM_BINS-1:0]   bin_valid_q, bin_valid_d;
  logic [BW-1:0]         bin_q, bin_d;
  logic [SW-1:0]         samples_q, samples_d;
  logic [WW-1:0]         win_q, win_d;
  logic [BW-1:0]         scan_idx_q, scan_idx_d;
  logic [BW-1:0]         cmp_idx_q, cmp_idx_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [BW-1:0]         best_q, best_d;
  logic [CNT_W-1:0]      best_cnt_q, best_cnt_d;
  logic [CLASS_W-1:0]    chosen_q, chosen_d;
  logic                  closed_q, closed_d;
  logic                  out_valid_q, out_valid_d;
  wcmf_out_t             out_data_q, out_data_d;

  // Histogram RAM.
  logic                  ram_we;
  logic [CNT_W-1:0]      ram_wdata;
  logic [BW-1:0]         ram_raddr;
  logic [CNT_W-1:0]      ram_rdata;

  // Input bin selection.
  logic [ID_W:0]         cls_inc;
  logic                  cls_ok;
  logic [BW-1:0]         in_bin;

  // Scan helpers.
  logic [LW-1:0]         last_wide;
  logic [BW-1:0]         last_bin;
  logic [CNT_W-1:0]      upd_cnt;
  logic [CNT_W-1:0]      cmp_cnt;
  logic                  cmp_better;
  logic [BW-1:0]         best_nxt;

  // Window and restart bookkeeping.
  logic [SW-1:0]         samples_inc;
  logic                  win_end;
  logic                  restart;

  wcmf_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BINS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (bin_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Map the sample to its bin: out-of-range or invalid samples go to bin 0.
  assign cls_inc = {1'b0, in_data_i.class_id} + (ID_W+1)'(1);
  assign cls_ok  = in_data_i.sample_valid
                && (in_data_i.class_id < ID_W'(num_cls_q))
                && (cls_inc < (ID_W+1)'(NUM_BINS));
  assign in_bin  = cls_ok ? BW'(cls_inc) : '0;

  // Last scanned bin: num_classes, cut off at the top of the histogram.
  assign last_wide = (LW'(num_cls_q) > LW'(NUM_BINS - 1)) ? LW'(NUM_BINS - 1)
                                                          : LW'(num_cls_q);
  assign last_bin  = BW'(last_wide);

  // Read the accepted bin while idle, otherwise the scan pointer.
  assign ram_raddr = (state_q == ST_IDLE) ? in_bin : scan_idx_q;

  // A bin whose valid flop is clear reads as zero; saturate at the maximum.
  assign upd_cnt   = bin_valid_q[bin_q] ? ram_rdata : '0;
  assign ram_wdata = (upd_cnt == BIN_MAX) ? upd_cnt : upd_cnt + CNT_W'(1);

  assign cmp_cnt    = bin_valid_q[cmp_idx_q] ? ram_rdata : '0;
  assign cmp_better = cmp_vld_q && (cmp_cnt > best_cnt_q);
  assign best_nxt   = cmp_better ? cmp_idx_q : best_q;

  assign samples_inc = samples_q + SW'(1);
  assign win_end     = (win_q == WW'(WINDOW_LEN - 1));
  assign restart     = (samples_inc > SW'(RESTART_LIMIT));

  always_comb begin
    state_d     = state_q;
    num_cls_d   = num_cls_q;
    bin_valid_d = bin_valid_q;
    bin_d       = bin_q;
    samples_d   = samples_q;
    win_d       = win_q;
    scan_idx_d  = scan_idx_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = cmp_vld_q;
    best_d      = best_q;
    best_cnt_d  = best_cnt_q;
    chosen_d    = chosen_q;
    closed_d    = closed_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;

    if (cfg_we_i) begin
      num_cls_d = cfg_wdata_i;
    end

    // Drop the output beat once taken.
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          bin_d   = in_bin;
          state_d = ST_UPD;
        end
      end

      ST_UPD: begin
        ram_we             = 1'b1;
        bin_valid_d[bin_q] = 1'b1;
        closed_d           = win_end;
        win_d              = win_end ? '0 : win_q + WW'(1);
        samples_d          = samples_inc;
        if (restart) begin
          samples_d = '0;
          win_d     = '0;
        end
        if (win_end) begin
          scan_idx_d = '0;
          cmp_vld_d  = 1'b0;
          best_d     = '0;
          best_cnt_d = '0;
          state_d    = ST_SCAN;
        end else begin
          if (restart) begin
            bin_valid_d = '0;
          end
          state_d = ST_FIN;
        end
      end

      ST_SCAN: begin
        cmp_vld_d = 1'b1;
        cmp_idx_d = scan_idx_q;
        if (cmp_better) begin
          best_d     = cmp_idx_q;
          best_cnt_d = cmp_cnt;
        end
        if (scan_idx_q == last_bin) begin
          state_d = ST_SCAN_END;
        end else begin
          scan_idx_d = scan_idx_q + BW'(1);
        end
      end

      ST_SCAN_END: begin
        // Take the final compare, commit the winner and clear the histogram.
        chosen_d    = CLASS_W'(best_nxt);
        bin_valid_d = '0;
        cmp_vld_d   = 1'b0;
        state_d     = ST_FIN;
      end

      ST_FIN: begin
        // Hold here until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d              = 1'b1;
          out_data_d.stable_class  = chosen_q;
          out_data_d.window_closed = closed_q;
          state_d                  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_cls_q   <= NUM_CLASSES_RST;
      bin_valid_q <= '0;
      bin_q       <= '0;
      samples_q   <= '0;
      win_q       <= '0;
      scan_idx_q  <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      best_q      <= '0;
      best_cnt_q  <= '0;
      chosen_q    <= '0;
      closed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      num_cls_q   <= num_cls_d;
      bin_valid_q <= bin_valid_d;
      bin_q       <= bin_d;
      samples_q   <= samples_d;
      win_q       <= win_d;
      scan_idx_q  <= scan_idx_d;
      cmp_idx_q   <= cmp_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      best_q      <= best_d;
      best_cnt_q  <= best_cnt_d;
      chosen_q    <= chosen_d;
      closed_q    <= closed_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `WCMF_ASSERT(a_accept_to_upd, (in_valid_i && in_ready_o) |=> (state_q == ST_UPD), "no update")
  `WCMF_ASSERT(a_scan_in_range, (state_q == ST_SCAN) |-> (scan_idx_q <= last_bin), "scan overran")
  `WCMF_ASSERT(a_scan_clears, (state_q == ST_SCAN_END) |=> (bin_valid_q == '0), "bins not cleared")
  `WCMF_ASSERT_ALWAYS(a_win_range, !rst_ni || (win_q <= WW'(WINDOW_LEN - 1)), "bad window count")

endmodule

@@ test/windowed_class_mode_filter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_class_mode_filter_tb
// Self-checking bench for the windowed class mode filter: a clocked driver
// feeds classification samples from a queue, a clocked monitor compares every
// output beat with a histogram predictor. The class count changes between
// phases, and both channels stall at random.
// ----------------------------------------------------------------------------
module windowed_class_mode_filter_tb;
  import wcmf_pkg::*;

  localparam int unsigned NUM_BINS      = NUM_BINS_DEF;
  localparam int unsigned WINDOW_LEN    = WINDOW_LEN_DEF;
  localparam int unsigned RESTART_LIMIT = RESTART_LIMIT_DEF;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_REPORTS   = 10;

  // Shapes of the sample stream of one phase.
  typedef enum logic [1:0] {
    MIX_SAMPLES,   // one dominant class plus scattered other classes and noise
    HIGH_SAMPLES,  // mostly classes 10 to 14
    TIE_SAMPLES,   // two bins in strict alternation
    RAW_SAMPLES    // every field fully random
  } stream_shape_e;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports
  // ---------------------------------------------------------------------------
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CLASS_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  wcmf_in_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  wcmf_out_t          out_data_o;

  always #6 clk_i = ~clk_i;

  windowed_class_mode_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // ---------------------------------------------------------------------------
  // Histogram predictor: its own copy of the bins, the sample counter, the
  // stable bin and the class count.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]   bin_tally [NUM_BINS];
  int unsigned        sample_count;
  logic [CLASS_W-1:0] stable_bin;
  logic [CLASS_W-1:0] class_limit;

  wcmf_in_t    samples_to_send[$];    // beats waiting for the driver
  wcmf_out_t   class_reports_due[$];  // predicted output beats, oldest first

  int unsigned mismatches;
  int unsigned beats_sent;
  int unsigned windows_closed;
  int unsigned restarts;
  int unsigned cycle_count;
  bit          send_calm;  // no input gaps during this phase
  bit          recv_calm;  // no output stalls during this phase

  function automatic void clear_tally();
    for (int b = 0; b < NUM_BINS; b++) begin
      bin_tally[b] = '0;
    end
  endfunction

  // Count one sample and return the output beat it causes.
  function automatic wcmf_out_t tally_sample(wcmf_in_t s);
    logic [CLASS_W-1:0] bin;
    int unsigned        scan_end;
    logic [CNT_W-1:0]   best_cnt;
    wcmf_out_t          r;
    bin = '0;
    r.window_closed = 1'b0;
    // Invalid samples and classes at or above the class count land in bin 0.
    if (s.sample_valid && s.class_id < class_limit && s.class_id + 1 < NUM_BINS) begin
      bin = s.class_id[CLASS_W-1:0] + 1'b1;
    end
    if (bin_tally[bin] < BIN_MAX) begin
      bin_tally[bin] = bin_tally[bin] + 1'b1;
    end
    sample_count++;
    // Window close: first bin with the highest count among 0..class_limit.
    if (sample_count % WINDOW_LEN == 0) begin
      scan_end = (class_limit > NUM_BINS - 1) ? NUM_BINS - 1 : class_limit;
      best_cnt = '0;
      stable_bin = '0;
      for (int unsigned b = 0; b <= scan_end; b++) begin
        if (bin_tally[b] > best_cnt) begin
          best_cnt   = bin_tally[b];
          stable_bin = b[CLASS_W-1:0];
        end
      end
      clear_tally();
      r.window_closed = 1'b1;
      windows_closed++;
    end
    // Restart keeps the stable bin.
    if (sample_count > RESTART_LIMIT) begin
      sample_count = 0;
      clear_tally();
      restarts++;
    end
    r.stable_class = stable_bin;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present the next queued sample, hold it until accepted, then idle
  // for a random gap.
  // ---------------------------------------------------------------------------
  int unsigned send_idle;

  always @(posedge clk_i) begin : driver
    bit hold;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_idle = 0;
    end else begin
      hold = in_valid_i && !in_ready_o;
      if (in_valid_i && in_ready_o) begin
        class_reports_due.push_back(tally_sample(in_data_i));
        beats_sent++;
      end
      if (!hold) begin
        if (send_idle > 0) begin
          send_idle--;
          in_valid_i <= 1'b0;
        end else if (samples_to_send.size() > 0) begin
          in_data_i  <= samples_to_send.pop_front();
          in_valid_i <= 1'b1;
          send_idle = send_calm ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted output beat against the oldest prediction,
  // then decide whether to stall the next one.
  // ---------------------------------------------------------------------------
  int unsigned recv_stall;

  always @(posedge clk_i) begin : monitor
    wcmf_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (class_reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] unexpected beat: stable_class %0d window_closed %0b",
                     $realtime, out_data_o.stable_class, out_data_o.window_closed);
          end
        end else begin
          want = class_reports_due.pop_front();
          if (out_data_o.stable_class !== want.stable_class ||
              out_data_o.window_closed !== want.window_closed) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("[%0t] beat differs: stable_class exp %0d got %0d, %s",
                       $realtime, want.stable_class, out_data_o.stable_class,
                       $sformatf("window_closed exp %0b got %0b",
                                 want.window_closed, out_data_o.window_closed));
            end
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!recv_calm && $urandom_range(0, 7) == 0) begin
          recv_stall = pick_gap();
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_count, class_reports_due.size());
      $display("windowed_class_mode_filter: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_sample(input logic valid, input logic [ID_W-1:0] id);
    wcmf_in_t s;
    s.sample_valid = valid;
    s.class_id     = id;
    samples_to_send.push_back(s);
  endtask

  // Hold until every queued sample went out and every result came back.
  task automatic wait_idle();
    while (samples_to_send.size() != 0 || in_valid_i || class_reports_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Write the class count; only called with the block idle.
  task automatic write_class_limit(input logic [CLASS_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    class_limit = v;
  endtask

  function automatic int unsigned samples_to_window_close();
    return WINDOW_LEN - (sample_count % WINDOW_LEN);
  endfunction

  // Queue n samples of the given shape for the current class count.
  task automatic queue_stream(input stream_shape_e shape, input int unsigned n);
    logic [ID_W-1:0] dominant;
    logic            tie_valid_a;
    logic [ID_W-1:0] tie_id_a;
    logic [ID_W-1:0] tie_id_b;
    int unsigned     r;
    dominant = '0;
    // Tie pair: bin 0 (invalid sample) against class 0 when at most one class
    // exists, otherwise two random classes in range.
    tie_valid_a = (class_limit > 1);
    tie_id_a    = (class_limit > 1) ? ID_W'($urandom_range(0, class_limit - 1)) : ID_W'(0);
    tie_id_b    = (class_limit > 1) ? ID_W'($urandom_range(0, class_limit - 1)) : ID_W'(0);
    if (class_limit > 1 && tie_id_b == tie_id_a) begin
      tie_id_b = ID_W'((tie_id_a + 1) % class_limit);
    end
    for (int unsigned i = 0; i < n; i++) begin
      if (i % WINDOW_LEN == 0) begin
        dominant = (class_limit > 0) ? ID_W'($urandom_range(0, class_limit - 1)) : ID_W'(0);
      end
      r = $urandom_range(0, 99);
      case (shape)
        MIX_SAMPLES: begin
          if (r < 8)       queue_sample(1'b0, ID_W'($urandom));
          else if (r < 16) queue_sample(1'b1, ID_W'($urandom));
          else if (r < 60) queue_sample(1'b1, dominant);
          else             queue_sample(1'b1, ID_W'($urandom_range(0, class_limit)));
        end
        HIGH_SAMPLES: begin
          if (r < 85) queue_sample(1'b1, ID_W'($urandom_range(10, 14)));
          else        queue_sample(1'($urandom), ID_W'($urandom));
        end
        TIE_SAMPLES: begin
          if (i % 2 == 0) queue_sample(tie_valid_a, tie_id_a);
          else            queue_sample(1'b1, tie_id_b);
        end
        default: begin
          queue_sample(1'($urandom), ID_W'($urandom));
        end
      endcase
    end
  endtask

  // One phase: new class count, fresh idling behavior, one stream, drain.
  task automatic run_phase(input logic [CLASS_W-1:0] limit, input stream_shape_e shape,
                           input int unsigned n);
    write_class_limit(limit);
    send_calm = ($urandom_range(0, 3) == 0);
    recv_calm = ($urandom_range(0, 3) == 0);
    queue_stream(shape, n);
    wait_idle();
  endtask

  initial begin : stimulus
    int unsigned n;
    clear_tally();
    sample_count   = 0;
    stable_bin     = '0;
    class_limit    = NUM_CLASSES_RST;
    mismatches     = 0;
    beats_sent     = 0;
    windows_closed = 0;
    restarts       = 0;
    cycle_count    = 0;
    send_calm      = 1'b0;
    recv_calm      = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at the reset class count: every class in range, the
    // first class out of range, invalid samples, and class_id bit patterns.
    queue_sample(1'b1, 8'd0);
    queue_sample(1'b1, 8'd1);
    queue_sample(1'b1, 8'd2);
    queue_sample(1'b1, 8'd3);
    queue_sample(1'b1, 8'd4);
    queue_sample(1'b1, 8'd255);
    queue_sample(1'b1, 8'h80);
    queue_sample(1'b1, 8'h55);
    queue_sample(1'b1, 8'hAA);
    queue_sample(1'b1, 8'h7F);
    queue_sample(1'b0, 8'd0);
    queue_sample(1'b0, 8'd3);
    queue_sample(1'b0, 8'd255);
    queue_sample(1'b1, 8'd3);
    queue_sample(1'b1, 8'd3);
    wait_idle();

    // Top class count: last bin (class 14) and class 15 out of range.
    write_class_limit(4'd15);
    queue_sample(1'b1, 8'd14);
    queue_sample(1'b1, 8'd15);
    queue_sample(1'b1, 8'd14);
    queue_sample(1'b1, 8'd0);
    wait_idle();

    run_phase(4'd15, MIX_SAMPLES, 200);

    // Fill high bins up to just before a window close, then narrow the scan
    // so those bins are left out; widen again to see they were cleared.
    n = samples_to_window_close();
    if (n < 20) n += WINDOW_LEN;
    run_phase(4'd15, HIGH_SAMPLES, n - 5);
    run_phase(4'd3, MIX_SAMPLES, 5);
    run_phase(4'd15, MIX_SAMPLES, 100);

    // Ties resolve to the lowest bin.
    run_phase(4'd1, TIE_SAMPLES, 200);
    run_phase(4'd6, TIE_SAMPLES, 100);

    // Zero classes: every sample lands in bin 0.
    run_phase(4'd0, MIX_SAMPLES, 100);
    run_phase(4'd7, RAW_SAMPLES, 150);

    // Random class counts; the run crosses the restart point in here.
    for (int k = 0; k < 3; k++) begin
      run_phase(CLASS_W'($urandom_range(0, 15)), MIX_SAMPLES, 120);
    end
    run_phase(4'd15, MIX_SAMPLES, 60);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (class_reports_due.size() != 0) begin
      $display("%0d predicted beats never arrived", class_reports_due.size());
      mismatches += class_reports_due.size();
    end

    $display("sent %0d samples, %0d window closes, %0d counter restarts",
             beats_sent, windows_closed, restarts);
    $display("class counts 0, 1, 3, 4, 6, 7, 15 and random ones; %0d mismatched beats",
             mismatches);
    if (mismatches == 0) begin
      $display("windowed_class_mode_filter: match");
    end else begin
      $display("windowed_class_mode_filter: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/wcmf_pkg.sv
sv/wcmf_ram.sv
sv/windowed_class_mode_filter.sv
test/windowed_class_mode_filter_tb.sv
